// ===== rtl/core/arp_pkg.sv =====
// arp_pkg: transaction structs, codes and reset values for the arp cache resolver
// no dependencies; imported by arp_cache_resolver
package arp_pkg;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] ip_address;
        logic [47:0] sender_mac;
        logic [15:0] hardware_type;
        logic [15:0] protocol_type;
        logic [15:0] arp_opcode;
        logic [31:0] query_ip;
        logic [15:0] ether_type;
        logic [7:0]  packet_handle;
        logic [10:0] packet_length;
    } arp_in_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] dst_mac;
        logic [31:0] peer_ip;
        logic [7:0]  out_handle;
        logic [15:0] out_ether_type;
        logic [10:0] out_length;
        logic        last;
    } arp_out_t;

    localparam int DEF_CACHE_ENTRIES = 16;
    localparam int DEF_QUEUE_SLOTS   = 8;

    localparam logic [1:0] CMD_ARP  = 2'd0;
    localparam logic [1:0] CMD_TX   = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [2:0] ACT_SEND    = 3'd0;
    localparam logic [2:0] ACT_REQUEST = 3'd1;
    localparam logic [2:0] ACT_REPLY   = 3'd2;
    localparam logic [2:0] ACT_DROP    = 3'd3;
    localparam logic [2:0] ACT_REJECT  = 3'd4;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_PENDING  = 2'd1;
    localparam logic [1:0] ST_RESOLVED = 2'd2;

    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [15:0] ARP_ETYPE   = 16'h0806;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;
    localparam logic [47:0] BCAST_MAC   = 48'hFFFF_FFFF_FFFF;

    localparam logic [2:0] REG_LOCAL_IP       = 3'd0;
    localparam logic [2:0] REG_LOCAL_MAC      = 3'd1;
    localparam logic [2:0] REG_RETRY_INTERVAL = 3'd2;
    localparam logic [2:0] REG_MAX_TRIES      = 3'd3;
    localparam logic [2:0] REG_MAX_LENGTH     = 3'd4;

    localparam logic [15:0] RST_RETRY_INTERVAL = 16'd100;
    localparam logic [3:0]  RST_MAX_TRIES      = 4'd4;
    localparam logic [10:0] RST_MAX_LENGTH     = 11'd1500;

    localparam logic [4:0] MAX_RESULTS = 5'd23;

    function automatic arp_out_t make_result(
        input logic [2:0]  act,
        input logic [47:0] mac,
        input logic [31:0] ip,
        input logic [7:0]  handle,
        input logic [15:0] etype,
        input logic [10:0] len
    );
        arp_out_t r;
        r.action         = act;
        r.dst_mac        = mac;
        r.peer_ip        = ip;
        r.out_handle     = handle;
        r.out_ether_type = etype;
        r.out_length     = len;
        r.last           = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/arp_cache_resolver.sv =====
// arp_cache_resolver: arp cache with pending packet queue, apb configuration
// depends on arp_pkg
//
// One command transaction is taken at a time; in_ready is high only while the
// sequencer is idle. A small sequencer walks the cache and the queue one entry a
// cycle, unless a result push stalls, through a single cache read port and a
// single queue slot compare. A reject ends after the check; a transmit first walks
// the whole cache, and one to a pending or unknown hop then searches the queue for
// a free slot; an arp walks the cache and then the queue. An entry evicted for a
// transmit to an unknown hop or an arp costs one more queue walk, and a tick walks
// every cache entry plus one queue walk per expired entry. Results leave through
// an output register plus one hold stage, so the last flag can be set on the final
// result, and a stalled out_ready stalls the sequencer only when a new result must
// be pushed, or the final held result moved out, while both stages are full.
// Configuration writes via apb take effect at once and must be made while the
// block is idle. No clearing pass is needed after reset.
module arp_cache_resolver #(
    parameter int CACHE_ENTRIES = arp_pkg::DEF_CACHE_ENTRIES,
    parameter int QUEUE_SLOTS   = arp_pkg::DEF_QUEUE_SLOTS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  arp_pkg::arp_in_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output arp_pkg::arp_out_t out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [5:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import arp_pkg::*;

    localparam int CIW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int SIW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam logic [CIW-1:0] C_LAST = CIW'(CACHE_ENTRIES - 1);
    localparam logic [SIW-1:0] S_LAST = SIW'(QUEUE_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_FIND, S_AFTER_FIND, S_ALLOC, S_QDROP, S_WRITE_RES,
        S_QSEND, S_REPLY, S_QPLACE, S_WRITE_PEND, S_TICK, S_TICK_NEXT, S_FINISH
    } state_t;

    // configuration
    logic [31:0] local_ip_reg;
    logic [47:0] local_mac_reg;
    logic [15:0] retry_interval_reg;
    logic [3:0]  max_tries_reg;
    logic [10:0] max_length_reg;

    // cache storage
    logic [1:0]  entry_status_reg [CACHE_ENTRIES];
    logic [31:0] entry_ip_reg     [CACHE_ENTRIES];
    logic [47:0] entry_mac_reg    [CACHE_ENTRIES];
    logic [31:0] entry_last_reg   [CACHE_ENTRIES];
    logic [3:0]  entry_tries_reg  [CACHE_ENTRIES];
    logic [CIW-1:0] evict_ptr_reg;
    logic [31:0] tick_reg;

    // queue storage
    logic        slot_used_reg   [QUEUE_SLOTS];
    logic [31:0] slot_hop_reg    [QUEUE_SLOTS];
    logic [7:0]  slot_handle_reg [QUEUE_SLOTS];
    logic [15:0] slot_etype_reg  [QUEUE_SLOTS];
    logic [10:0] slot_len_reg    [QUEUE_SLOTS];

    // sequencer context
    state_t      state_reg;
    state_t      ret_reg;
    arp_in_t     item_reg;
    logic [CIW-1:0] idx_reg;
    logic [SIW-1:0] sidx_reg;
    logic        found_reg;
    logic [CIW-1:0] found_idx_reg;
    logic        free_v_reg;
    logic [CIW-1:0] free_idx_reg;
    logic [CIW-1:0] ent_reg;
    logic [31:0] key_reg;
    logic [4:0]  cnt_reg;

    // result staging
    logic        hold_valid_reg;
    arp_out_t    hold_reg;
    logic        out_valid_reg;
    arp_out_t    out_reg;

    logic [CIW-1:0] rd_idx;
    logic [1:0]  rd_status;
    logic [31:0] rd_ip;
    logic [47:0] rd_mac;
    logic [31:0] rd_last;
    logic [3:0]  rd_tries;
    logic        slot_hit;
    logic        tick_due;
    logic        emit_req;
    arp_out_t    emit_data;
    logic        out_free;
    logic        push_ok;
    logic        suppress;
    logic        fire;
    logic        stall;
    logic        last_push;
    arp_out_t    out_load_data;
    logic        cfg_we;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[5:3])
            REG_LOCAL_IP:       prdata = {32'd0, local_ip_reg};
            REG_LOCAL_MAC:      prdata = {16'd0, local_mac_reg};
            REG_RETRY_INTERVAL: prdata = {48'd0, retry_interval_reg};
            REG_MAX_TRIES:      prdata = {60'd0, max_tries_reg};
            REG_MAX_LENGTH:     prdata = {53'd0, max_length_reg};
            default:            prdata = 64'd0;
        endcase
    end

    // single cache read port
    always_comb
    begin
        case (state_reg)
            S_ALLOC:      rd_idx = evict_ptr_reg;
            S_AFTER_FIND: rd_idx = found_idx_reg;
            default:      rd_idx = idx_reg;
        endcase
    end

    assign rd_status = entry_status_reg[rd_idx];
    assign rd_ip     = entry_ip_reg[rd_idx];
    assign rd_mac    = entry_mac_reg[rd_idx];
    assign rd_last   = entry_last_reg[rd_idx];
    assign rd_tries  = entry_tries_reg[rd_idx];

    assign slot_hit = slot_used_reg[sidx_reg] && (slot_hop_reg[sidx_reg] == key_reg);
    assign tick_due = (tick_reg - rd_last) >= {16'd0, retry_interval_reg};

    // result generation for the current sequencer step
    always_comb
    begin
        emit_req  = 1'b0;
        emit_data = make_result(ACT_SEND, 48'd0, 32'd0, 8'd0, 16'd0, 11'd0);
        case (state_reg)
            S_CHECK:
            begin
                if (item_reg.command == CMD_TX && item_reg.packet_length > max_length_reg)
                begin
                    emit_req  = 1'b1;
                    emit_data = make_result(ACT_REJECT, 48'd0, 32'd0, item_reg.packet_handle,
                                            item_reg.ether_type, item_reg.packet_length);
                end
            end
            S_AFTER_FIND:
            begin
                if (item_reg.command == CMD_TX && found_reg && rd_status == ST_RESOLVED)
                begin
                    emit_req  = 1'b1;
                    emit_data = make_result(ACT_SEND, rd_mac, 32'd0, item_reg.packet_handle,
                                            item_reg.ether_type, item_reg.packet_length);
                end
            end
            S_QDROP:
            begin
                if (slot_hit)
                begin
                    emit_req  = 1'b1;
                    emit_data = make_result(ACT_DROP, 48'd0, 32'd0, slot_handle_reg[sidx_reg],
                                            slot_etype_reg[sidx_reg], slot_len_reg[sidx_reg]);
                end
            end
            S_QSEND:
            begin
                if (slot_hit)
                begin
                    emit_req  = 1'b1;
                    emit_data = make_result(ACT_SEND, item_reg.sender_mac, 32'd0,
                                            slot_handle_reg[sidx_reg],
                                            slot_etype_reg[sidx_reg], slot_len_reg[sidx_reg]);
                end
            end
            S_REPLY:
            begin
                if (item_reg.arp_opcode == OP_REQUEST && item_reg.query_ip == local_ip_reg)
                begin
                    emit_req  = 1'b1;
                    emit_data = make_result(ACT_REPLY, item_reg.sender_mac, item_reg.ip_address,
                                            8'd0, ARP_ETYPE, 11'd0);
                end
            end
            S_QPLACE:
            begin
                if (slot_used_reg[sidx_reg] && sidx_reg == S_LAST)
                begin
                    emit_req  = 1'b1;
                    emit_data = make_result(ACT_DROP, 48'd0, 32'd0, item_reg.packet_handle,
                                            item_reg.ether_type, item_reg.packet_length);
                end
            end
            S_WRITE_PEND:
            begin
                emit_req  = 1'b1;
                emit_data = make_result(ACT_REQUEST, BCAST_MAC, item_reg.ip_address,
                                        8'd0, ARP_ETYPE, 11'd0);
            end
            S_TICK:
            begin
                if (rd_status == ST_PENDING && tick_due && rd_tries < max_tries_reg)
                begin
                    emit_req  = 1'b1;
                    emit_data = make_result(ACT_REQUEST, BCAST_MAC, rd_ip, 8'd0, ARP_ETYPE, 11'd0);
                end
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign push_ok   = !hold_valid_reg || out_free;
    assign suppress  = (cnt_reg >= MAX_RESULTS);
    assign fire      = emit_req && !suppress && push_ok;
    assign stall     = emit_req && !suppress && !push_ok;
    // final held result moves to the output flagged last
    assign last_push = (state_reg == S_FINISH) && hold_valid_reg && out_free;

    always_comb
    begin
        out_load_data      = hold_reg;
        out_load_data.last = last_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            ret_reg            <= S_IDLE;
            local_ip_reg       <= 32'd0;
            local_mac_reg      <= 48'd0;
            retry_interval_reg <= RST_RETRY_INTERVAL;
            max_tries_reg      <= RST_MAX_TRIES;
            max_length_reg     <= RST_MAX_LENGTH;
            for (int i = 0; i < CACHE_ENTRIES; i++)
            begin
                entry_status_reg[i] <= ST_FREE;
            end
            for (int j = 0; j < QUEUE_SLOTS; j++)
            begin
                slot_used_reg[j] <= 1'b0;
            end
            evict_ptr_reg  <= '0;
            tick_reg       <= 32'd0;
            cnt_reg        <= 5'd0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                case (paddr[5:3])
                    REG_LOCAL_IP:       local_ip_reg       <= pwdata[31:0];
                    REG_LOCAL_MAC:      local_mac_reg      <= pwdata[47:0];
                    REG_RETRY_INTERVAL: retry_interval_reg <= pwdata[15:0];
                    REG_MAX_TRIES:      max_tries_reg      <= pwdata[3:0];
                    REG_MAX_LENGTH:     max_length_reg     <= pwdata[10:0];
                    default:            ;
                endcase
            end

            // result staging: output register drains, hold stage feeds it
            if ((fire && hold_valid_reg) || last_push)
            begin
                out_reg       <= out_load_data;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                hold_reg       <= emit_data;
                hold_valid_reg <= 1'b1;
                cnt_reg        <= cnt_reg + 5'd1;
            end
            else if (last_push)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (!stall)
            begin
                case (state_reg)
                    S_IDLE:
                    begin
                        if (in_valid)
                        begin
                            item_reg <= in_data;
                            cnt_reg  <= 5'd0;
                            if (in_data.command == CMD_TICK)
                            begin
                                tick_reg <= tick_reg + 32'd1;
                            end
                            state_reg <= S_CHECK;
                        end
                    end
                    S_CHECK:
                    begin
                        idx_reg    <= '0;
                        found_reg  <= 1'b0;
                        free_v_reg <= 1'b0;
                        case (item_reg.command)
                            CMD_ARP:
                            begin
                                if (item_reg.hardware_type == HW_ETHERNET &&
                                    item_reg.protocol_type == PROTO_IPV4)
                                begin
                                    state_reg <= S_FIND;
                                end
                                else
                                begin
                                    state_reg <= S_FINISH;
                                end
                            end
                            CMD_TX:
                            begin
                                if (item_reg.packet_length > max_length_reg)
                                begin
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    state_reg <= S_FIND;
                                end
                            end
                            CMD_TICK: state_reg <= S_TICK;
                            default:  state_reg <= S_FINISH;
                        endcase
                    end
                    S_FIND:
                    begin
                        // one entry a cycle: match on ip and first free entry
                        if (rd_status != ST_FREE && rd_ip == item_reg.ip_address && !found_reg)
                        begin
                            found_reg     <= 1'b1;
                            found_idx_reg <= idx_reg;
                        end
                        if (rd_status == ST_FREE && !free_v_reg)
                        begin
                            free_v_reg   <= 1'b1;
                            free_idx_reg <= idx_reg;
                        end
                        if (idx_reg == C_LAST)
                        begin
                            state_reg <= S_AFTER_FIND;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    S_AFTER_FIND:
                    begin
                        sidx_reg <= '0;
                        if (item_reg.command == CMD_ARP)
                        begin
                            if (found_reg)
                            begin
                                ent_reg   <= found_idx_reg;
                                state_reg <= S_WRITE_RES;
                            end
                            else
                            begin
                                ret_reg   <= S_WRITE_RES;
                                state_reg <= S_ALLOC;
                            end
                        end
                        else if (found_reg && rd_status == ST_RESOLVED)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            state_reg <= S_QPLACE;
                        end
                    end
                    S_ALLOC:
                    begin
                        sidx_reg <= '0;
                        if (free_v_reg)
                        begin
                            ent_reg   <= free_idx_reg;
                            state_reg <= ret_reg;
                        end
                        else
                        begin
                            // round-robin victim, its queued packets are dropped
                            ent_reg       <= evict_ptr_reg;
                            key_reg       <= rd_ip;
                            evict_ptr_reg <= (evict_ptr_reg == C_LAST) ? '0 :
                                             evict_ptr_reg + 1'b1;
                            state_reg     <= S_QDROP;
                        end
                    end
                    S_QDROP:
                    begin
                        if (slot_hit)
                        begin
                            slot_used_reg[sidx_reg] <= 1'b0;
                        end
                        if (sidx_reg == S_LAST)
                        begin
                            state_reg <= ret_reg;
                        end
                        else
                        begin
                            sidx_reg <= sidx_reg + 1'b1;
                        end
                    end
                    S_WRITE_RES:
                    begin
                        entry_ip_reg[ent_reg]     <= item_reg.ip_address;
                        entry_mac_reg[ent_reg]    <= item_reg.sender_mac;
                        entry_status_reg[ent_reg] <= ST_RESOLVED;
                        key_reg                   <= item_reg.ip_address;
                        sidx_reg                  <= '0;
                        state_reg                 <= S_QSEND;
                    end
                    S_QSEND:
                    begin
                        if (slot_hit)
                        begin
                            slot_used_reg[sidx_reg] <= 1'b0;
                        end
                        if (sidx_reg == S_LAST)
                        begin
                            state_reg <= S_REPLY;
                        end
                        else
                        begin
                            sidx_reg <= sidx_reg + 1'b1;
                        end
                    end
                    S_REPLY:
                    begin
                        state_reg <= S_FINISH;
                    end
                    S_QPLACE:
                    begin
                        if (!slot_used_reg[sidx_reg] || sidx_reg == S_LAST)
                        begin
                            if (!slot_used_reg[sidx_reg])
                            begin
                                slot_used_reg[sidx_reg]   <= 1'b1;
                                slot_hop_reg[sidx_reg]    <= item_reg.ip_address;
                                slot_handle_reg[sidx_reg] <= item_reg.packet_handle;
                                slot_etype_reg[sidx_reg]  <= item_reg.ether_type;
                                slot_len_reg[sidx_reg]    <= item_reg.packet_length;
                            end
                            if (found_reg)
                            begin
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                ret_reg   <= S_WRITE_PEND;
                                state_reg <= S_ALLOC;
                            end
                        end
                        else
                        begin
                            sidx_reg <= sidx_reg + 1'b1;
                        end
                    end
                    S_WRITE_PEND:
                    begin
                        entry_ip_reg[ent_reg]     <= item_reg.ip_address;
                        entry_status_reg[ent_reg] <= ST_PENDING;
                        entry_tries_reg[ent_reg]  <= 4'd1;
                        entry_last_reg[ent_reg]   <= tick_reg;
                        state_reg                 <= S_FINISH;
                    end
                    S_TICK:
                    begin
                        if (rd_status == ST_PENDING && tick_due)
                        begin
                            if (rd_tries >= max_tries_reg)
                            begin
                                // expiry: free the entry, drop what waits on it
                                entry_status_reg[idx_reg] <= ST_FREE;
                                key_reg                   <= rd_ip;
                                sidx_reg                  <= '0;
                                ret_reg                   <= S_TICK_NEXT;
                                state_reg                 <= S_QDROP;
                            end
                            else
                            begin
                                entry_tries_reg[idx_reg] <= rd_tries + 4'd1;
                                entry_last_reg[idx_reg]  <= tick_reg;
                                state_reg                <= S_TICK_NEXT;
                            end
                        end
                        else
                        begin
                            state_reg <= S_TICK_NEXT;
                        end
                    end
                    S_TICK_NEXT:
                    begin
                        if (idx_reg == C_LAST)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_TICK;
                        end
                    end
                    S_FINISH:
                    begin
                        // leave once the final held result has moved out
                        if (!hold_valid_reg || out_free)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

`ifndef ASSERT_OFF
    // nothing is left in the hold stage once the sequencer is idle
    a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !hold_valid_reg)
        else $error("hold stage not empty in idle");

    // result count never passes the per-item limit
    a_result_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_RESULTS)
        else $error("result count above limit");

    // a result is only pushed while a transaction is being worked on
    a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> state_reg != S_IDLE && state_reg != S_FINISH)
        else $error("result pushed outside item processing");
`endif

endmodule
